// ===== design/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int CNT_W       = 11;
  localparam int OWNER_IN_W  = 8;
  localparam int OWNER_IN_IW = $clog2(OWNER_IN_W);
  localparam int START_W     = 10;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_SPACE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FILL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             is_free;
    logic             region;
    logic [CNT_W-1:0] count;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [START_W-1:0] start_block;
  } res_t;

endpackage

// ===== design/ffba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/ffba_engine.sv =====
// Scan, fill and clear sequencer around the block owner memory.
`timescale 1ns / 1ps
module ffba_engine import ffba_pkg::*; #(
  parameter int TOTAL_BLOCKS = 1024,
  parameter int RT_BLOCKS    = 64,
  parameter int OWNER_WIDTH  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  req_t                   req_i,
  input  logic [OWNER_WIDTH-1:0] id_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output res_t                   res_o
);

  localparam int AW     = $clog2(TOTAL_BLOCKS);
  localparam int CW     = AW + 1;
  localparam int SW     = (CW > CNT_W) ? CW : CNT_W;
  localparam int DW     = OWNER_WIDTH + 1;
  localparam int RT_EFF = (RT_BLOCKS < TOTAL_BLOCKS) ? RT_BLOCKS : TOTAL_BLOCKS;
  localparam logic [CW-1:0] RtC  = CW'(RT_EFF);
  localparam logic [CW-1:0] TotC = CW'(TOTAL_BLOCKS);

  state_e               state_q, state_d;
  logic [CW-1:0]        addr_q, addr_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        pend_addr_q, pend_addr_d;
  logic [CNT_W-1:0]     run_q, run_d;
  logic [AW-1:0]        start_q, start_d;
  status_e              status_q, status_d;
  req_t                 req_q, req_d;
  logic [OWNER_WIDTH-1:0] id_q, id_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [DW-1:0] mem_rdata;

  logic [CW-1:0] lo, hi, size;
  logic          too_large;
  logic          hit_free;
  logic          found;
  logic          scan_end;
  logic [AW-1:0] run_start;
  logic [CNT_W-1:0] run_inc;

  ffba_ram #(
    .WIDTH (DW),
    .DEPTH (TOTAL_BLOCKS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    lo        = req_q.region ? RtC : '0;
    hi        = req_q.region ? TotC : RtC;
    size      = hi - lo;
    too_large = SW'(req_q.count) > SW'(size);
    run_inc   = run_q + CNT_W'(1);
    run_start = (run_q == '0) ? pend_addr_q : start_q;
    hit_free  = pend_q && !mem_rdata[OWNER_WIDTH];
    found     = hit_free && !req_q.is_free && (run_inc == req_q.count);
    scan_end  = !pend_q && (addr_q >= hi);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (addr_q == TotC - CW'(1)) state_d = S_IDLE;
      S_IDLE:  if (req_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        if (!req_q.is_free && (too_large || req_q.count == '0)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (found) begin
          state_d = S_FILL;
        end else if (scan_end) begin
          state_d = S_DONE;
        end
      end
      S_FILL:  if (run_q == CNT_W'(1)) state_d = S_DONE;
      S_DONE:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    addr_d      = addr_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    run_d       = run_q;
    start_d     = start_q;
    status_d    = status_q;
    req_d       = req_q;
    id_d        = id_q;
    mem_we      = 1'b0;
    mem_waddr   = pend_addr_q;
    mem_wdata   = '0;
    req_ready_o = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);
    res_o.status      = status_q;
    res_o.start_block = START_W'(start_q);

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q[AW-1:0];
        addr_d    = addr_q + CW'(1);
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
          id_d  = id_i;
        end
      end
      S_CHECK: begin
        addr_d   = lo;
        run_d    = '0;
        start_d  = '0;
        status_d = too_large ? ST_TOO_LARGE : ST_NO_SPACE;
      end
      S_SCAN: begin
        if (addr_q < hi) begin
          addr_d      = addr_q + CW'(1);
          pend_d      = 1'b1;
          pend_addr_d = addr_q[AW-1:0];
        end
        if (pend_q) begin
          if (req_q.is_free) begin
            if (mem_rdata[OWNER_WIDTH] && mem_rdata[OWNER_WIDTH-1:0] == id_q) begin
              mem_we    = 1'b1;
              mem_waddr = pend_addr_q;
              mem_wdata = '0;
            end
          end else if (hit_free) begin
            start_d = run_start;
            run_d   = run_inc;
          end else begin
            run_d = '0;
          end
        end
        if (found) begin
          addr_d   = CW'(run_start);
          pend_d   = 1'b0;
          run_d    = req_q.count;
          start_d  = run_start;
          status_d = ST_OK;
        end else if (scan_end) begin
          start_d  = '0;
          status_d = req_q.is_free ? ST_OK : ST_NO_SPACE;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q[AW-1:0];
        mem_wdata = {1'b1, id_q};
        addr_d    = addr_q + CW'(1);
        run_d     = run_q - CNT_W'(1);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    run_q       <= run_d;
    start_q     <= start_d;
    status_q    <= status_d;
    req_q       <= req_d;
    id_q        <= id_d;
  end

endmodule

// ===== design/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: request intake and result register.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, req_type_i, region_i,        | request
//          | owner_id_i, block_count_i                            |
//  out     | out_valid_o, out_ready_i, status_o, start_block_o    | result
//
// One request at a time; the owner memory is read and written one block per cycle.
// Allocate: scan to the first fitting run (the whole region if none fits), then fill
// it. Free: scan of the whole region. Size or zero-count failures skip the scan.
// After reset all TOTAL_BLOCKS blocks are cleared before the first request.
// A waiting result is held in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int TOTAL_BLOCKS = 1024,
  parameter int RT_BLOCKS    = 64,
  parameter int OWNER_WIDTH  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic                  region_i,
  input  logic [OWNER_IN_W-1:0] owner_id_i,
  input  logic [CNT_W-1:0]      block_count_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [START_W-1:0]    start_block_o
);

  req_t                   req;
  logic [OWNER_WIDTH-1:0] id;
  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;

  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q, status_d;
  logic [START_W-1:0]     start_q, start_d;

  always_comb begin
    req.is_free = req_type_i;
    req.region  = region_i;
    req.count   = block_count_i;
    for (int b = 0; b < OWNER_WIDTH; b++) begin
      id[b] = (b < OWNER_IN_W) ? owner_id_i[OWNER_IN_IW'(b)] : 1'b0;
    end
  end

  ffba_engine #(
    .TOTAL_BLOCKS (TOTAL_BLOCKS),
    .RT_BLOCKS    (RT_BLOCKS),
    .OWNER_WIDTH  (OWNER_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (req),
    .id_i        (id),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_comb begin
    res_ready   = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    start_d     = start_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      status_d    = res.status;
      start_d     = res.start_block;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    start_q  <= start_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign start_block_o = start_q;

endmodule
